>>> rtl/ax25d_pkg.sv
// Shared types and constants for the AX.25 UI frame deframer.
// Used by the parser, the result register and the top level; no dependencies.
`timescale 1ns / 1ps

package ax25d_pkg;

    localparam int MAX_ADDRESSES = 10;

    localparam logic [7:0] FEND_BYTE = 8'hC0;
    localparam logic [7:0] CTRL_UI   = 8'h03;
    localparam logic [7:0] PID_NONE  = 8'hF0;

    localparam logic [2:0] KIND_ADDRESS   = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD   = 3'd1;
    localparam logic [2:0] KIND_FRAME_END = 3'd2;
    localparam logic [2:0] KIND_NOT_UI    = 3'd3;
    localparam logic [2:0] KIND_TRUNCATED = 3'd4;
    localparam logic [2:0] KIND_TOO_MANY  = 3'd5;

    typedef struct packed {
        logic [2:0]  kind;
        logic [41:0] address_chars;
        logic [2:0]  call_length;
        logic [3:0]  ssid;
        logic [3:0]  address_index;
        logic        address_last;
        logic [7:0]  data_byte;
    } t_result;

endpackage

>>> rtl/ax25d_parser.sv
// Frame parser: phase tracking, address assembly and result formation.
// Depends on ax25d_pkg.
`timescale 1ns / 1ps

module ax25d_parser
    import ax25d_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  logic [7:0] i_byte,
    output logic    o_res_valid,
    output t_result o_res
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_CMD     = 3'd1;
    localparam logic [2:0] PH_ADDR    = 3'd2;
    localparam logic [2:0] PH_CTRL    = 3'd3;
    localparam logic [2:0] PH_PID     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_DISCARD = 3'd6;

    logic [2:0]  r_phase, n_phase;
    logic [2:0]  r_byte_in_block, n_byte_in_block;
    logic [3:0]  r_block_count, n_block_count;
    logic [47:0] r_address_shift, n_address_shift;

    logic [41:0] w_chars;
    logic [2:0]  w_len;
    logic        w_ends;

    // Unpack the six stored address bytes into 7-bit characters and find
    // the length left after trailing spaces and zeros are dropped.
    always_comb begin
        w_chars = '0;
        w_len   = '0;
        for (int k = 0; k < 6; k++) begin
            w_chars[41 - 7 * k -: 7] = r_address_shift[47 - 8 * k -: 7];
            if (r_address_shift[47 - 8 * k -: 7] != 7'h20 &&
                r_address_shift[47 - 8 * k -: 7] != 7'h00) begin
                w_len = 3'(k + 1);
            end
        end
    end

    assign w_ends = i_byte[0] && (r_block_count != 4'd0);

    always_comb begin
        n_phase         = r_phase;
        n_byte_in_block = r_byte_in_block;
        n_block_count   = r_block_count;
        n_address_shift = r_address_shift;
        o_res_valid     = 1'b0;
        o_res           = '0;

        if (i_byte == FEND_BYTE) begin
            n_phase         = PH_CMD;
            n_byte_in_block = '0;
            n_block_count   = '0;
            n_address_shift = '0;
            if (r_phase == PH_ADDR || r_phase == PH_CTRL || r_phase == PH_PID) begin
                o_res_valid = 1'b1;
                o_res.kind  = KIND_TRUNCATED;
            end else if (r_phase == PH_PAYLOAD) begin
                o_res_valid = 1'b1;
                o_res.kind  = KIND_FRAME_END;
            end
        end else begin
            case (r_phase)
                PH_CMD: begin
                    n_phase         = PH_ADDR;
                    n_byte_in_block = '0;
                    n_block_count   = '0;
                    n_address_shift = '0;
                end
                PH_ADDR: begin
                    if (r_byte_in_block == 3'd0 &&
                        r_block_count >= 4'(MAX_ADDRESSES)) begin
                        n_phase     = PH_DISCARD;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_TOO_MANY;
                    end else if (r_byte_in_block < 3'd6) begin
                        n_address_shift = {r_address_shift[39:0], i_byte};
                        n_byte_in_block = r_byte_in_block + 3'd1;
                    end else begin
                        o_res_valid         = 1'b1;
                        o_res.kind          = KIND_ADDRESS;
                        o_res.address_chars = w_chars;
                        o_res.call_length   = w_len;
                        o_res.ssid          = i_byte[4:1];
                        o_res.address_index = r_block_count;
                        o_res.address_last  = w_ends;
                        n_byte_in_block     = '0;
                        n_address_shift     = '0;
                        if (w_ends) begin
                            n_phase = PH_CTRL;
                        end else begin
                            n_block_count = r_block_count + 4'd1;
                        end
                    end
                end
                PH_CTRL: begin
                    if (i_byte == CTRL_UI) begin
                        n_phase = PH_PID;
                    end else begin
                        n_phase     = PH_DISCARD;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_NOT_UI;
                    end
                end
                PH_PID: begin
                    if (i_byte == PID_NONE) begin
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase     = PH_DISCARD;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_NOT_UI;
                    end
                end
                PH_PAYLOAD: begin
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_PAYLOAD;
                    o_res.data_byte = i_byte;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_byte_in_block <= '0;
            r_block_count   <= '0;
            r_address_shift <= '0;
        end else if (i_advance) begin
            r_phase         <= n_phase;
            r_byte_in_block <= n_byte_in_block;
            r_block_count   <= n_block_count;
            r_address_shift <= n_address_shift;
        end
    end

endmodule

>>> rtl/ax25d_out_reg.sv
// Result register that holds one finished result until the sink takes it.
// Depends on ax25d_pkg.
`timescale 1ns / 1ps

module ax25d_out_reg
    import ax25d_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_take,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> rtl/ax25_ui_frame_deframer.sv
// Top level of the AX.25 UI frame deframer: input register, parser, result register.
// Depends on ax25d_pkg, ax25d_parser and ax25d_out_reg.
`timescale 1ns / 1ps

// The deframer takes one byte of a KISS stream per request on the slave side
// and gives at most one result per byte on the master side. A 0xC0 opens a
// frame; the KISS command byte after it is skipped. Each 7-byte address block
// gives an address result (kind 0) with six 7-bit characters, trimmed length,
// SSID and block index; tlast marks the block that ends the address list.
// After control 0x03 and PID 0xF0, every byte is a payload result (kind 1)
// until a 0xC0 closes the frame (kind 2). A wrong control or PID gives kind 3,
// a 0xC0 inside the header gives kind 4, and more than MAX_ADDRESSES blocks
// give kind 5; after kinds 3 and 5 bytes are dropped until the next 0xC0.
// Bytes are taken one per cycle while the sink keeps tready high: a byte
// accepted into the input register is parsed straight out of it, and its
// result is loaded into the result register when the byte moves on. A
// result thus passes the input register and the result register before it
// reaches the master side. A held result stalls the input register, which
// in turn deasserts slave tready.
module ax25_ui_frame_deframer
    import ax25d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [41:0] address_chars, [44:42] call_length,
                                     // [48:45] ssid, [52:49] address_index,
                                     // [60:53] data_byte, [63:61] zero
    output logic [2:0]  o_m_tuser,   // [2:0] kind
    output logic        o_m_tlast    // address_last
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_out_free;
    logic       w_advance;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out_res;

    // The registered byte moves on whenever the result register can take
    // whatever it produces.
    assign w_out_free = !o_m_tvalid || i_m_tready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    ax25d_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_byte      (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    ax25d_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance && w_res_valid),
        .i_res   (w_res),
        .i_take  (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_res   (w_out_res)
    );

    assign o_m_tdata = {3'b000, w_out_res.data_byte, w_out_res.address_index,
                        w_out_res.ssid, w_out_res.call_length,
                        w_out_res.address_chars};
    assign o_m_tuser = w_out_res.kind;
    assign o_m_tlast = w_out_res.address_last;

endmodule
